@@ rtl/core/ewbp_pkg.sv @@
`default_nettype none

package ewbp_pkg;

    localparam int NUM_BINS = 12;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 8;
    localparam int COORD_W  = 8;
    localparam int LOC_W    = 5;

    localparam logic [COORD_W-1:0] WIN_LO     = 8'd114;
    localparam logic [COORD_W-1:0] WIN_HI     = 8'd141;
    localparam logic [LOC_W-1:0]   BIN_SPAN   = 5'd8;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 8'd255;
    localparam logic [CNT_W-1:0]   SLOTS_MAX  = 8'd255;
    localparam logic [CNT_W-1:0]   MAX_EVENTS = 8'd150;
    localparam logic [IDX_W-1:0]   FIRST_BIN  = 4'd0;
    localparam logic [IDX_W-1:0]   LAST_BIN   = 4'(NUM_BINS - 1);

    localparam logic [LOC_W-1:0] BIN_X_LO [NUM_BINS] =
        '{5'd5, 5'd14, 5'd0, 5'd5, 5'd14, 5'd19, 5'd0, 5'd5, 5'd14, 5'd19, 5'd5, 5'd14};
    localparam logic [LOC_W-1:0] BIN_Y_LO [NUM_BINS] =
        '{5'd0, 5'd0, 5'd5, 5'd5, 5'd5, 5'd5, 5'd14, 5'd14, 5'd14, 5'd14, 5'd19, 5'd19};

    typedef logic [NUM_BINS-1:0] bin_mask_t;
    typedef logic [NUM_BINS-1:0][CNT_W-1:0] count_array_t;

    typedef struct packed {
        logic         load;
        count_array_t counts;
    } scan_load_t;

endpackage

`default_nettype wire

@@ rtl/core/ewbp_if.sv @@
`default_nettype none

interface ewbp_event_if
    import ewbp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic               scan_end;

    modport source (output valid, event_x, event_y, scan_end, input ready);
    modport sink   (input valid, event_x, event_y, scan_end, output ready);
endinterface

interface ewbp_bin_if
    import ewbp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;
    logic             last_bin;

    modport source (output valid, bin_index, bin_count, last_bin, input ready);
    modport sink   (input valid, bin_index, bin_count, last_bin, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ewbp_match.sv @@
`default_nettype none

module ewbp_match
    import ewbp_pkg::*;
(
    input  wire logic [COORD_W-1:0] x,
    input  wire logic [COORD_W-1:0] y,
    output bin_mask_t               hit
);

    logic             in_win;
    logic [LOC_W-1:0] lx;
    logic [LOC_W-1:0] ly;

    always_comb
    begin
        in_win = (x >= WIN_LO) && (x <= WIN_HI) && (y >= WIN_LO) && (y <= WIN_HI);
        lx     = LOC_W'(x - WIN_LO);
        ly     = LOC_W'(y - WIN_LO);
        for (int i = 0; i < NUM_BINS; i++)
        begin
            hit[i] = in_win
                && (lx >= BIN_X_LO[i]) && (lx <= LOC_W'(BIN_X_LO[i] + BIN_SPAN))
                && (ly >= BIN_Y_LO[i]) && (ly <= LOC_W'(BIN_Y_LO[i] + BIN_SPAN));
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ewbp_accum.sv @@
`default_nettype none

module ewbp_accum
    import ewbp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ewbp_event_if.sink  evt,
    input  wire logic   snap_free,
    output scan_load_t  scan_load
);

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               end_reg;
    logic               valid_reg;
    count_array_t       cnt_reg;
    count_array_t       cnt_next;
    logic               stop_reg;
    logic               stop_next;
    logic [CNT_W-1:0]   slots_reg;
    logic [CNT_W-1:0]   slots_next;

    bin_mask_t    hit;
    count_array_t upd;
    logic         advance;
    logic         accept;
    logic         examine;
    logic         sentinel;

    ewbp_match u_match (
        .x   (x_reg),
        .y   (y_reg),
        .hit (hit)
    );

    always_comb
    begin
        advance   = valid_reg && (!end_reg || snap_free);
        evt.ready = !valid_reg || advance;
        accept    = evt.valid && evt.ready;
        examine   = !stop_reg && (slots_reg < MAX_EVENTS);
        sentinel  = (x_reg == '0) && (y_reg == '0);

        for (int i = 0; i < NUM_BINS; i++)
        begin
            upd[i] = cnt_reg[i];
            if (examine && !sentinel && hit[i] && (cnt_reg[i] != CNT_MAX))
            begin
                upd[i] = cnt_reg[i] + 1'b1;
            end
        end

        cnt_next   = cnt_reg;
        stop_next  = stop_reg;
        slots_next = slots_reg;
        if (advance)
        begin
            if (end_reg)
            begin
                cnt_next   = '0;
                stop_next  = 1'b0;
                slots_next = '0;
            end
            else
            begin
                cnt_next   = upd;
                stop_next  = stop_reg || (examine && sentinel);
                slots_next = (slots_reg == SLOTS_MAX) ? slots_reg : slots_reg + 1'b1;
            end
        end

        scan_load.load   = advance && end_reg;
        scan_load.counts = upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            stop_reg  <= 1'b0;
            slots_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
            cnt_reg   <= cnt_next;
            stop_reg  <= stop_next;
            slots_reg <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= evt.event_x;
            y_reg   <= evt.event_y;
            end_reg <= evt.scan_end;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ewbp_drain.sv @@
`default_nettype none

module ewbp_drain
    import ewbp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  scan_load_t scan_load,
    output logic       snap_free,
    ewbp_bin_if.source res
);

    count_array_t     snap_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             active_reg;
    logic             take;
    logic             last_take;

    always_comb
    begin
        res.valid     = active_reg;
        res.bin_index = idx_reg;
        res.bin_count = snap_reg[0];
        res.last_bin  = (idx_reg == LAST_BIN);
        take          = active_reg && res.ready;
        last_take     = take && (idx_reg == LAST_BIN);
        snap_free     = !active_reg || last_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= FIRST_BIN;
        end
        else if (scan_load.load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= FIRST_BIN;
        end
        else if (take)
        begin
            active_reg <= !last_take;
            idx_reg    <= idx_reg + 1'b1;
        end
    end

    // shift the snapshot so the current bin always sits at position zero
    always_ff @(posedge clk)
    begin
        if (scan_load.load)
        begin
            snap_reg <= scan_load.counts;
        end
        else if (take)
        begin
            for (int i = 0; i < NUM_BINS - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i+1];
            end
            snap_reg[NUM_BINS-1] <= '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/event_window_bin_pooling.sv @@
// Event window bin pooling: one scan slot (event_x, event_y, scan_end) is taken per transfer
// on evt, and events inside the 28x28 window at origin 114 are counted into twelve
// overlapping 9x9 bins; an all-zero coordinate stops counting for the rest of the scan and
// only the first 150 slots of a scan are examined. A slot is accepted every cycle unless an
// end-of-scan slot is held back; it sits in the input register, then updates the counters.
// After the last slot of a scan, the twelve counts leave on res one per cycle while res is
// ready, in bin order, starting once that slot has left the input register, with last_bin
// high on bin 11. The snapshot that feeds res holds one scan, so an end-of-scan slot waits
// in the input register until the previous scan's twelve counts have all been taken; a scan
// of fewer than 12 slots is paced by the drain on res, and any stall on res slows it further.
`default_nettype none

module event_window_bin_pooling
    import ewbp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ewbp_event_if.sink  evt,
    ewbp_bin_if.source  res
);

    scan_load_t scan_load;
    logic       snap_free;

    ewbp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .snap_free (snap_free),
        .scan_load (scan_load)
    );

    ewbp_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_load (scan_load),
        .snap_free (snap_free),
        .res       (res)
    );

`ifndef ASSERT_OFF
    a_load_starts_at_first: assert property (@(posedge clk) disable iff (!rst_n)
        scan_load.load |=> (res.valid && (res.bin_index == FIRST_BIN)))
        else $error("snapshot load did not start at bin zero");

    a_no_early_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && !res.last_bin) |=> res.valid)
        else $error("drain stopped before the last bin");

    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last_bin && !scan_load.load) |=> !res.valid)
        else $error("drain continued past the last bin");
`endif

endmodule

`default_nettype wire

@@ sim/event_window_bin_pooling_test.sv @@
`timescale 1ns / 100ps

module event_window_bin_pooling_test;
    import ewbp_pkg::*;

    localparam int WINDOW_LO   = 114;
    localparam int WINDOW_HI   = 141;
    localparam int BIN_WIDTH   = 8;
    localparam int EVENT_LIMIT = 150;
    localparam int BIN_TOTAL   = 12;
    localparam int BIN_COL_LO [BIN_TOTAL] = '{5, 14, 0, 5, 14, 19, 0, 5, 14, 19, 5, 14};
    localparam int BIN_ROW_LO [BIN_TOTAL] = '{0, 0, 5, 5, 5, 5, 14, 14, 14, 14, 19, 19};

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               scan_end;
    } slot_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic             last_bin;
    } bin_result_t;

    logic clk;
    logic rst_n;

    ewbp_event_if evt_if ();
    ewbp_bin_if   res_if ();

    event_window_bin_pooling u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if.sink),
        .res   (res_if.source)
    );

    slot_t       pending_slots [$];
    bin_result_t due_counts [$];

    logic [CNT_W-1:0] bin_tally [BIN_TOTAL];
    logic             counting_halted;
    logic [CNT_W-1:0] slot_tally;

    int mismatch_count = 0;
    int slots_taken    = 0;
    int scans_closed   = 0;
    int bins_checked   = 0;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic take_slot(input slot_t s);
        int          i;
        int          lx;
        int          ly;
        bin_result_t r;
        if (!counting_halted && slot_tally < EVENT_LIMIT)
        begin
            if (s.x == 0 && s.y == 0)
            begin
                counting_halted = 1'b1;
            end
            else if (s.x >= WINDOW_LO && s.x <= WINDOW_HI &&
                     s.y >= WINDOW_LO && s.y <= WINDOW_HI)
            begin
                lx = int'(s.x) - WINDOW_LO;
                ly = int'(s.y) - WINDOW_LO;
                for (i = 0; i < BIN_TOTAL; i++)
                begin
                    if (lx >= BIN_COL_LO[i] && lx <= BIN_COL_LO[i] + BIN_WIDTH &&
                        ly >= BIN_ROW_LO[i] && ly <= BIN_ROW_LO[i] + BIN_WIDTH &&
                        bin_tally[i] != 8'hFF)
                        bin_tally[i]++;
                end
            end
        end
        if (slot_tally != 8'hFF)
            slot_tally++;
        if (s.scan_end)
        begin
            for (i = 0; i < BIN_TOTAL; i++)
            begin
                r.bin_index = IDX_W'(i);
                r.bin_count = bin_tally[i];
                r.last_bin  = (i == BIN_TOTAL - 1);
                due_counts.push_back(r);
                bin_tally[i] = '0;
            end
            counting_halted = 1'b0;
            slot_tally      = '0;
            scans_closed++;
        end
    endtask

    task automatic check_bin(input bin_result_t got);
        bin_result_t want;
        if (due_counts.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected count for bin %0d", got.bin_index));
        end
        else
        begin
            want = due_counts.pop_front();
            if (got.bin_index !== want.bin_index)
                flag_mismatch($sformatf("bin_index %0d, want %0d",
                                        got.bin_index, want.bin_index));
            if (got.bin_count !== want.bin_count)
                flag_mismatch($sformatf("bin %0d: bin_count %0d, want %0d",
                                        want.bin_index, got.bin_count, want.bin_count));
            if (got.last_bin !== want.last_bin)
                flag_mismatch($sformatf("bin %0d: last_bin %0b, want %0b",
                                        want.bin_index, got.last_bin, want.last_bin));
            bins_checked++;
        end
    endtask

    task automatic add_slot(input int x, input int y, input bit fin);
        slot_t s;
        s.x        = COORD_W'(x);
        s.y        = COORD_W'(y);
        s.scan_end = fin;
        pending_slots.push_back(s);
    endtask

    function automatic int pick_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return $urandom_range(WINDOW_HI, WINDOW_LO);
        else if (roll < 80)
            return $urandom_range(WINDOW_HI + 2, WINDOW_LO - 2);
        else
            return $urandom_range(255, 0);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int k;

        rst_n           = 1'b0;
        evt_if.valid    = 1'b0;
        evt_if.event_x  = '0;
        evt_if.event_y  = '0;
        evt_if.scan_end = 1'b0;
        res_if.ready    = 1'b0;
        for (k = 0; k < BIN_TOTAL; k++)
            bin_tally[k] = '0;
        counting_halted = 1'b0;
        slot_tally      = '0;

        // window corners, edges just outside, off-window extremes
        add_slot(114, 114, 0);
        add_slot(141, 141, 0);
        add_slot(127, 127, 0);
        add_slot(113, 120, 0);
        add_slot(142, 120, 0);
        add_slot(120, 113, 0);
        add_slot(120, 142, 0);
        add_slot(0, 255, 0);
        add_slot(255, 0, 0);
        add_slot(255, 255, 0);
        add_slot(123, 123, 1);
        // sentinel mid-scan stops counting
        add_slot(120, 120, 0);
        add_slot(0, 0, 0);
        add_slot(120, 120, 1);
        // single-slot scans, sentinel as last slot
        add_slot(119, 119, 1);
        add_slot(0, 0, 1);
        add_slot(133, 133, 1);
        add_slot(128, 119, 1);
        add_slot(141, 114, 1);

        // long random scan just past the slot limit, last slot inside the window
        for (k = 0; k < 151; k++)
            add_slot(pick_coord(), pick_coord(), 0);
        add_slot(127, 127, 1);
        add_slot(133, 133, 1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_slots.size() != 0 || evt_if.valid || due_counts.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        $display("%0d slots over %0d scans taken, %0d bin counts compared",
                 slots_taken, scans_closed, bins_checked);
        $display("scans covered sentinel, window edges, slot limit and back-to-back ends");
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #500000;
        $display("simulation failed");
        $finish;
    end

    // hold the slot until transfer; no gaps while slots 60 to 139 go in
    always @(posedge clk or negedge rst_n)
    begin
        slot_t nxt;
        bit    gap;
        if (!rst_n)
        begin
            evt_if.valid    <= 1'b0;
            evt_if.event_x  <= '0;
            evt_if.event_y  <= '0;
            evt_if.scan_end <= 1'b0;
        end
        else
        begin
            if (evt_if.valid && evt_if.ready)
            begin
                nxt.x        = evt_if.event_x;
                nxt.y        = evt_if.event_y;
                nxt.scan_end = evt_if.scan_end;
                take_slot(nxt);
                slots_taken++;
            end
            if (!evt_if.valid || evt_if.ready)
            begin
                gap = !(slots_taken >= 60 && slots_taken < 140) && $urandom_range(99) < 8;
                if (pending_slots.size() != 0 && !gap)
                begin
                    nxt = pending_slots.pop_front();
                    evt_if.event_x  <= nxt.x;
                    evt_if.event_y  <= nxt.y;
                    evt_if.scan_end <= nxt.scan_end;
                    evt_if.valid    <= 1'b1;
                end
                else
                begin
                    evt_if.valid <= 1'b0;
                end
            end
        end
    end

    // no stalls while bin counts 24 to 83 come out
    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t got;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.bin_index = res_if.bin_index;
                got.bin_count = res_if.bin_count;
                got.last_bin  = res_if.last_bin;
                check_bin(got);
            end
            res_if.ready <= (bins_checked >= 24 && bins_checked < 84) ||
                            $urandom_range(99) >= 8;
        end
    end

endmodule
